FILE: rtl/core/ocwg_pkg.sv
// ----------------------------------------------------------------------------
// ocwg_pkg
// Shared types, register codes and the carrier table builder for the OOK
// command waveform generator.
// ----------------------------------------------------------------------------
package ocwg_pkg;

    // Fixed field widths
    localparam int SAMPLE_BITS        = 16;
    localparam int ONES_BITS          = 7;
    localparam int SYNC_PATTERN_BITS  = 16;
    localparam int SYNC_IDX_BITS      = $clog2(SYNC_PATTERN_BITS);
    localparam int SYNC_LEN_BITS      = 5;
    localparam int REPS_BITS          = 4;
    localparam int SPS_BITS           = 8;
    localparam int STEP_BITS          = 32;
    localparam int BIT_IDX_BITS       = 8;
    localparam int CFG_INDEX_BITS     = 3;
    localparam int CFG_DATA_BITS      = 32;

    // Frame limits
    localparam int MAX_SYNC_BITS      = 16;
    localparam logic [ONES_BITS-1:0] ONES_CAP = 7'd100;

    // Opcode of an input item
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Carrier table constants: pi in Q30, series length
    localparam longint unsigned PI_Q30      = 64'd3373259426;
    localparam int              SERIES_TERMS = 24;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SYNC_PATTERN       = 3'd0,
        CFG_SYNC_LENGTH        = 3'd1,
        CFG_REPETITIONS        = 3'd2,
        CFG_SAMPLES_PER_SYMBOL = 3'd3,
        CFG_PHASE_STEP         = 3'd4
    } cfg_index_e;

    // Input item
    typedef struct packed {
        logic                 opcode;
        logic [ONES_BITS-1:0] ones_count;
    } ocwg_in_t;

    // Result item
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          active;
        logic                          last;
    } ocwg_out_t;

    // Configuration register file contents
    typedef struct packed {
        logic [SYNC_PATTERN_BITS-1:0] sync_pattern;
        logic [SYNC_LEN_BITS-1:0]     sync_length;
        logic [REPS_BITS-1:0]         repetitions;
        logic [SPS_BITS-1:0]          samples_per_symbol;
        logic [STEP_BITS-1:0]         phase_step;
    } ocwg_cfg_t;

    // Per-sample control from the sequencer to the carrier stage
    typedef struct packed {
        logic active;
        logic carrier_on;
        logic last;
    } ocwg_tone_t;

    // One carrier table entry: round(A*cos(2*pi*k/2^addr_bits)), evaluated
    // with a Q30 quarter-wave Taylor series. Elaboration time only.
    function automatic logic signed [SAMPLE_BITS-1:0] cos_entry(int k, int addr_bits);
        longint unsigned x;
        longint unsigned term;
        longint unsigned m;
        longint unsigned sc;
        longint unsigned amp;
        longint unsigned r;
        longint          c;
        longint          s;
        longint          v;
        longint          res;
        int              q;
        int              n;
        amp  = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
        q    = (k >> (addr_bits - 2)) & 3;
        r    = 64'(k & ((1 << (addr_bits - 2)) - 1));
        x    = (PI_Q30 * r + (64'd1 << (addr_bits - 2))) >> (addr_bits - 1);
        term = 64'd1 << 30;
        c    = 64'sd1 << 30;
        s    = 64'sd0;
        for (n = 1; n <= SERIES_TERMS; n++) begin
            term = (term * x + (64'd1 << 29)) >> 30;
            term = (term + 64'(n >> 1)) / 64'(n);
            case (n & 3)
                1:       s = s + longint'(term);
                2:       c = c - longint'(term);
                3:       s = s - longint'(term);
                default: c = c + longint'(term);
            endcase
        end
        case (q)
            0:       v = c;
            1:       v = -s;
            2:       v = -c;
            default: v = s;
        endcase
        m  = (v < 0) ? longint'(-v) : longint'(v);
        sc = (m * amp + (64'd1 << 29)) >> 30;
        if (sc > amp) begin
            sc = amp;
        end
        res = (v < 0) ? -longint'(sc) : longint'(sc);
        return SAMPLE_BITS'(res);
    endfunction

endpackage

FILE: rtl/core/ocwg_sequencer.sv
// ----------------------------------------------------------------------------
// ocwg_sequencer
// Frame state (symbol, bit and repeat counters, phase accumulator) and the
// first pipeline register: keying bit, table address and frame flags.
// ----------------------------------------------------------------------------
module ocwg_sequencer
    import ocwg_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  ocwg_in_t                   item,
    input  ocwg_cfg_t                  cfg,
    output ocwg_tone_t                 tone,
    output logic [TABLE_ADDR_BITS-1:0] addr
);

    // Frame state
    logic                    busy_reg, busy_next;
    logic [PHASE_BITS-1:0]   phase_reg, phase_next;
    logic [SPS_BITS-1:0]     sis_reg, sis_next;
    logic [BIT_IDX_BITS-1:0] bit_idx_reg, bit_idx_next;
    logic [REPS_BITS-1:0]    rep_reg, rep_next;
    logic [ONES_BITS-1:0]    ones_reg, ones_next;

    // Stage register toward the carrier table
    ocwg_tone_t                 tone_reg, tone_next;
    logic [TABLE_ADDR_BITS-1:0] addr_reg, addr_next;

    // Current-sample view, with a start folded in
    logic                    start;
    logic                    cur_busy;
    logic [PHASE_BITS-1:0]   cur_phase;
    logic [SPS_BITS-1:0]     cur_sis;
    logic [BIT_IDX_BITS-1:0] cur_bit_idx;
    logic [REPS_BITS-1:0]    cur_rep;
    logic [ONES_BITS-1:0]    cur_ones;
    logic [SYNC_LEN_BITS-1:0] slen;
    logic [BIT_IDX_BITS-1:0] unit_len;
    logic [REPS_BITS-1:0]    reps;
    logic [SPS_BITS-1:0]     sps;
    logic                    key_bit;
    logic                    end_sym, end_unit, end_rep;

    always_comb
    begin
        start       = (item.opcode == OP_START);
        cur_busy    = start | busy_reg;
        cur_phase   = start ? '0 : phase_reg;
        cur_sis     = start ? '0 : sis_reg;
        cur_bit_idx = start ? '0 : bit_idx_reg;
        cur_rep     = start ? '0 : rep_reg;
        if (start)
            cur_ones = (item.ones_count > ONES_CAP) ? ONES_CAP : item.ones_count;
        else
            cur_ones = ones_reg;

        // Live register bounds, out-of-range values clamped
        if (cfg.sync_length == '0)
            slen = SYNC_LEN_BITS'(1);
        else if (cfg.sync_length > SYNC_LEN_BITS'(MAX_SYNC_BITS))
            slen = SYNC_LEN_BITS'(MAX_SYNC_BITS);
        else
            slen = cfg.sync_length;
        unit_len = BIT_IDX_BITS'(slen) + BIT_IDX_BITS'({cur_ones, 1'b0});
        reps     = (cfg.repetitions == '0) ? REPS_BITS'(1) : cfg.repetitions;
        sps      = (cfg.samples_per_symbol == '0) ? SPS_BITS'(1) : cfg.samples_per_symbol;

        // Sync bits first, then 1,0 pairs
        if (cur_bit_idx < BIT_IDX_BITS'(slen))
            key_bit = cfg.sync_pattern[cur_bit_idx[SYNC_IDX_BITS-1:0]];
        else
            key_bit = ~(cur_bit_idx[0] ^ slen[0]);

        end_sym  = ({1'b0, cur_sis} + 1'b1) >= {1'b0, sps};
        end_unit = ({1'b0, cur_bit_idx} + 1'b1) >= {1'b0, unit_len};
        end_rep  = ({1'b0, cur_rep} + 1'b1) >= {1'b0, reps};

        // Counter advance; an idle tick leaves everything in place
        busy_next    = busy_reg;
        phase_next   = cur_phase;
        sis_next     = cur_sis;
        bit_idx_next = cur_bit_idx;
        rep_next     = cur_rep;
        ones_next    = cur_ones;
        if (cur_busy)
        begin
            busy_next  = 1'b1;
            phase_next = cur_phase + cfg.phase_step[PHASE_BITS-1:0];
            if (end_sym)
            begin
                sis_next = '0;
                if (end_unit)
                begin
                    bit_idx_next = '0;
                    if (end_rep)
                    begin
                        rep_next  = '0;
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        rep_next = cur_rep + 1'b1;
                    end
                end
                else
                begin
                    bit_idx_next = cur_bit_idx + 1'b1;
                end
            end
            else
            begin
                sis_next = cur_sis + 1'b1;
            end
        end

        tone_next.active     = cur_busy;
        tone_next.carrier_on = cur_busy & key_bit;
        tone_next.last       = cur_busy & end_sym & end_unit & end_rep;
        addr_next            = cur_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS];
    end

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            phase_reg   <= '0;
            sis_reg     <= '0;
            bit_idx_reg <= '0;
            rep_reg     <= '0;
            ones_reg    <= '0;
        end
        else if (load)
        begin
            busy_reg    <= busy_next;
            phase_reg   <= phase_next;
            sis_reg     <= sis_next;
            bit_idx_reg <= bit_idx_next;
            rep_reg     <= rep_next;
            ones_reg    <= ones_next;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tone_reg <= tone_next;
            addr_reg <= addr_next;
        end
    end

    assign tone = tone_reg;
    assign addr = addr_reg;

endmodule

FILE: rtl/core/ocwg_carrier_rom.sv
// ----------------------------------------------------------------------------
// ocwg_carrier_rom
// Cosine table ROM with registered read; forms the output sample register.
// ----------------------------------------------------------------------------
module ocwg_carrier_rom
    import ocwg_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = 10
) (
    input  logic                       clk,
    input  logic                       load,
    input  ocwg_tone_t                 tone,
    input  logic [TABLE_ADDR_BITS-1:0] addr,
    output ocwg_out_t                  result
);

    localparam int TBL_SIZE = 1 << TABLE_ADDR_BITS;

    logic signed [SAMPLE_BITS-1:0] rom [TBL_SIZE];
    ocwg_out_t                     result_reg;

    // Table contents fixed at elaboration
    for (genvar k = 0; k < TBL_SIZE; k++)
    begin : g_rom
        localparam logic signed [SAMPLE_BITS-1:0] ENTRY = cos_entry(k, TABLE_ADDR_BITS);
        assign rom[k] = ENTRY;
    end

    // Registered read, keyed off when the bit is 0 or the frame is idle
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg.sample <= tone.carrier_on ? rom[addr] : '0;
            result_reg.active <= tone.active;
            result_reg.last   <= tone.last;
        end
    end

    assign result = result_reg;

endmodule

FILE: rtl/core/ook_command_waveform_generator.sv
// ----------------------------------------------------------------------------
// ook_command_waveform_generator
// On-off keyed command waveform with an NCO carrier, one sample per item.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------
//  in      | input     | in_valid/in_ready  | in_data   (opcode, ones_count)
//  out     | output    | out_valid/out_ready| out_data  (sample, active, last)
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One item per cycle sustained while out_ready is high; each item passes the
//  sequencer register, then the registered cosine ROM read, to result valid.
//  in_ready drops only while both stages are full and out_ready is low.
//  cfg_ready is always high; a register write takes effect the next cycle.
//  Reset empties the pipeline, ends any frame and loads register defaults.
// ----------------------------------------------------------------------------
module ook_command_waveform_generator
    import ocwg_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  ocwg_in_t                  in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output ocwg_out_t                 out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    ocwg_cfg_t                  cfg_reg;
    logic                       a_valid_reg, a_valid_next;
    logic                       b_valid_reg, b_valid_next;
    logic                       a_load, b_load;
    ocwg_tone_t                 tone;
    logic [TABLE_ADDR_BITS-1:0] addr;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_pattern       <= 16'd30583;
            cfg_reg.sync_length        <= 5'd16;
            cfg_reg.repetitions        <= 4'd8;
            cfg_reg.samples_per_symbol <= 8'd22;
            cfg_reg.phase_step         <= 32'd973915486;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SYNC_PATTERN:       cfg_reg.sync_pattern <= cfg_data[SYNC_PATTERN_BITS-1:0];
                CFG_SYNC_LENGTH:        cfg_reg.sync_length <= cfg_data[SYNC_LEN_BITS-1:0];
                CFG_REPETITIONS:        cfg_reg.repetitions <= cfg_data[REPS_BITS-1:0];
                CFG_SAMPLES_PER_SYMBOL: cfg_reg.samples_per_symbol <= cfg_data[SPS_BITS-1:0];
                CFG_PHASE_STEP:         cfg_reg.phase_step <= cfg_data[STEP_BITS-1:0];
                default:                ;
            endcase
        end
    end

    // Two-stage pipeline flow control
    always_comb
    begin
        b_load       = a_valid_reg && (!b_valid_reg || out_ready);
        in_ready     = !a_valid_reg || !b_valid_reg || out_ready;
        a_load       = in_valid && in_ready;
        a_valid_next = a_load ? 1'b1 : (b_load ? 1'b0 : a_valid_reg);
        b_valid_next = b_load ? 1'b1 : (out_ready ? 1'b0 : b_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    assign out_valid = b_valid_reg;

    ocwg_sequencer #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_sequencer (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (a_load),
        .item  (in_data),
        .cfg   (cfg_reg),
        .tone  (tone),
        .addr  (addr)
    );

    ocwg_carrier_rom #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_carrier_rom (
        .clk    (clk),
        .load   (b_load),
        .tone   (tone),
        .addr   (addr),
        .result (out_data)
    );

endmodule

FILE: rtl/core/ocwg_checker.sv
// ----------------------------------------------------------------------------
// ocwg_checker
// Port-level checks for the OOK command waveform generator, bound to the top.
// ----------------------------------------------------------------------------
module ocwg_checker
    import ocwg_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input ocwg_out_t out_data
);

    // A stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // Input backpressure only comes from a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // Carrier only inside a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.sample != '0) |-> out_data.active)
        else $error("nonzero sample outside a frame");

    // Frame end marker only on frame samples
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last |-> out_data.active)
        else $error("last flagged on an idle sample");

endmodule

bind ook_command_waveform_generator ocwg_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

FILE: bench/ocwg_waveform_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ocwg_waveform_checker
// Watches the item, result and register channels of the OOK command waveform
// generator. It keeps its own copy of the registers and the frame state, works
// out the sample due for every transferred item, and compares each result
// transfer with the oldest sample still owed.
// ----------------------------------------------------------------------------
module ocwg_waveform_checker
    import ocwg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  ocwg_in_t                  in_data,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  ocwg_out_t                 out_data,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                        failures,
    output int                        pending
);

    localparam int ACC_BITS      = 32;
    localparam int LUT_ADDR_BITS = 10;
    localparam int LUT_DEPTH     = 1 << LUT_ADDR_BITS;

    // Register values after reset
    localparam logic [SYNC_PATTERN_BITS-1:0] RST_PATTERN = 16'd30583;
    localparam logic [SYNC_LEN_BITS-1:0]     RST_LENGTH  = 5'd16;
    localparam logic [REPS_BITS-1:0]         RST_REPS    = 4'd8;
    localparam logic [SPS_BITS-1:0]          RST_SPS     = 8'd22;
    localparam logic [STEP_BITS-1:0]         RST_STEP    = 32'd973915486;

    logic signed [SAMPLE_BITS-1:0] carrier_rom [0:LUT_DEPTH-1];

    // Register copy and frame state
    ocwg_cfg_t               regs;
    logic                    keying;
    logic [ACC_BITS-1:0]     phase_acc;
    logic [SPS_BITS-1:0]     sym_pos;
    logic [BIT_IDX_BITS-1:0] bit_pos;
    logic [REPS_BITS-1:0]    rep_pos;
    logic [ONES_BITS-1:0]    ones_held;

    ocwg_out_t owed_samples [$];

    // Cosine level for one table address, Q30 quarter-wave series then scaled
    function automatic logic signed [SAMPLE_BITS-1:0] cosine_level(int addr);
        longint unsigned span;
        longint unsigned arg;
        longint unsigned term;
        longint unsigned mag;
        longint unsigned amp;
        longint          cos_q30;
        longint          sin_q30;
        longint          val;
        int              quad;
        int              n;
        amp     = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
        quad    = addr / (LUT_DEPTH / 4);
        span    = longint'(addr % (LUT_DEPTH / 4));
        arg     = (PI_Q30 * span + (64'd1 << (LUT_ADDR_BITS - 2))) >> (LUT_ADDR_BITS - 1);
        term    = 64'd1 << 30;
        cos_q30 = 64'sd1 << 30;
        sin_q30 = 64'sd0;
        for (n = 1; n <= 24; n++)
        begin
            term = (term * arg + (64'd1 << 29)) >> 30;
            term = (term + longint'(n / 2)) / longint'(n);
            if (n % 4 == 1)
                sin_q30 += longint'(term);
            else if (n % 4 == 2)
                cos_q30 -= longint'(term);
            else if (n % 4 == 3)
                sin_q30 -= longint'(term);
            else
                cos_q30 += longint'(term);
        end
        if (quad == 0)
            val = cos_q30;
        else if (quad == 1)
            val = -sin_q30;
        else if (quad == 2)
            val = -cos_q30;
        else
            val = sin_q30;
        mag = (val < 0) ? longint'(-val) : longint'(val);
        mag = (mag * amp + (64'd1 << 29)) >> 30;
        if (mag > amp)
            mag = amp;
        return (val < 0) ? SAMPLE_BITS'(-longint'(mag)) : SAMPLE_BITS'(mag);
    endfunction

    initial
    begin
        for (int a = 0; a < LUT_DEPTH; a++)
            carrier_rom[a] = cosine_level(a);
    end

    // Sample owed for one item; advances the frame state
    function automatic ocwg_out_t next_sample(ocwg_in_t item);
        ocwg_out_t   res;
        int unsigned sync_bits;
        int unsigned unit_bits;
        int unsigned rep_limit;
        int unsigned sym_limit;
        logic        keyed;
        logic        sym_done;
        logic        unit_done;
        logic        rep_done;
        res = '0;
        if (item.opcode == OP_START)
        begin
            ones_held = (item.ones_count > ONES_CAP) ? ONES_CAP : item.ones_count;
            keying    = 1'b1;
            phase_acc = '0;
            sym_pos   = '0;
            bit_pos   = '0;
            rep_pos   = '0;
        end
        if (!keying)
            return res;

        // Live register bounds, out-of-range values folded in
        sync_bits = (regs.sync_length == 0) ? 1 : regs.sync_length;
        if (sync_bits > MAX_SYNC_BITS)
            sync_bits = MAX_SYNC_BITS;
        unit_bits = sync_bits + 2 * ones_held;
        rep_limit = (regs.repetitions == 0) ? 1 : regs.repetitions;
        sym_limit = (regs.samples_per_symbol == 0) ? 1 : regs.samples_per_symbol;

        // Sync bits first, then 1,0 pairs
        if (bit_pos < sync_bits)
            keyed = regs.sync_pattern[bit_pos];
        else
            keyed = ((bit_pos - sync_bits) & 1) == 0;

        if (keyed)
            res.sample = carrier_rom[phase_acc[ACC_BITS-1 -: LUT_ADDR_BITS]];
        sym_done   = sym_pos + 1 >= sym_limit;
        unit_done  = bit_pos + 1 >= unit_bits;
        rep_done   = rep_pos + 1 >= rep_limit;
        res.active = 1'b1;
        res.last   = sym_done && unit_done && rep_done;

        phase_acc = phase_acc + regs.phase_step;
        if (!sym_done)
            sym_pos++;
        else
        begin
            sym_pos = '0;
            if (!unit_done)
                bit_pos++;
            else
            begin
                bit_pos = '0;
                if (!rep_done)
                    rep_pos++;
                else
                begin
                    rep_pos = '0;
                    keying  = 1'b0;
                end
            end
        end
        return res;
    endfunction

    // Channel monitor
    always @(posedge clk or negedge rst_n)
    begin
        ocwg_out_t want;
        if (!rst_n)
        begin
            regs.sync_pattern       = RST_PATTERN;
            regs.sync_length        = RST_LENGTH;
            regs.repetitions        = RST_REPS;
            regs.samples_per_symbol = RST_SPS;
            regs.phase_step         = RST_STEP;
            keying    = 1'b0;
            phase_acc = '0;
            sym_pos   = '0;
            bit_pos   = '0;
            rep_pos   = '0;
            ones_held = '0;
            owed_samples.delete();
            failures  = 0;
        end
        else
        begin
            // Item transfer: the sample uses registers as they stood before this edge
            if (in_valid && in_ready)
                owed_samples.push_back(next_sample(in_data));

            // Register write transfer; unknown indexes are dropped
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SYNC_PATTERN:
                        regs.sync_pattern       = cfg_data[SYNC_PATTERN_BITS-1:0];
                    CFG_SYNC_LENGTH:
                        regs.sync_length        = cfg_data[SYNC_LEN_BITS-1:0];
                    CFG_REPETITIONS:
                        regs.repetitions        = cfg_data[REPS_BITS-1:0];
                    CFG_SAMPLES_PER_SYMBOL:
                        regs.samples_per_symbol = cfg_data[SPS_BITS-1:0];
                    CFG_PHASE_STEP:
                        regs.phase_step         = cfg_data[STEP_BITS-1:0];
                    default: ;
                endcase
            end

            // Result transfer against the oldest owed sample
            if (out_valid && out_ready)
            begin
                if (owed_samples.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected result: expected none, actual %0d %0b %0b",
                             $time, out_data.sample, out_data.active, out_data.last);
                end
                else
                begin
                    want = owed_samples.pop_front();
                    if (out_data.sample !== want.sample)
                    begin
                        failures++;
                        $display("%0t: sample mismatch: expected %0d, actual %0d",
                                 $time, want.sample, out_data.sample);
                    end
                    if (out_data.active !== want.active)
                    begin
                        failures++;
                        $display("%0t: active mismatch: expected %0b, actual %0b",
                                 $time, want.active, out_data.active);
                    end
                    if (out_data.last !== want.last)
                    begin
                        failures++;
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, want.last, out_data.last);
                    end
                end
            end
        end
        pending = owed_samples.size();
    end

endmodule

FILE: bench/ook_command_waveform_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ook_command_waveform_generator_tb
// Drives the OOK command waveform generator with a short directed sequence
// and then random tick and start items under a series of register settings,
// with random gaps on the item side and random back-pressure on the result
// side. A checker beside the block predicts and compares every sample.
// ----------------------------------------------------------------------------
module ook_command_waveform_generator_tb;
    import ocwg_pkg::*;

    localparam int RESET_CYCLES    = 7;
    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int DRAIN_CYCLES    = 6;
    localparam int STUCK_LIMIT     = 2000;
    localparam int INDEX_SPAN      = 1 << CFG_INDEX_BITS;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    ocwg_in_t                  in_data;
    logic                      out_valid;
    logic                      out_ready;
    ocwg_out_t                 out_data;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    int   failures;
    int   pending;
    int   stuck_cycles;
    logic calm;

    ook_command_waveform_generator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ocwg_waveform_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .failures  (failures),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side back-pressure: flowing stretches, then stall bursts
    initial
    begin
        out_ready = 1'b1;
        forever
        begin
            repeat ($urandom_range(1, 40)) @(negedge clk);
            if (!calm)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Watchdog: cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if (!rst_n)
            stuck_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("ook_command_waveform_generator_tb: FAIL");
            $finish;
        end
    end

    // One item transfer, then sometimes a gap on the item side
    task automatic send_item(ocwg_in_t item);
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 15);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_op(logic op, int ones);
        ocwg_in_t item;
        item.opcode     = op;
        item.ones_count = ONES_BITS'(ones);
        send_item(item);
    endtask

    // One register write transfer; valid stays up for a following write
    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_settings(logic [CFG_DATA_BITS-1:0] pattern,
                                  logic [CFG_DATA_BITS-1:0] length,
                                  logic [CFG_DATA_BITS-1:0] reps,
                                  logic [CFG_DATA_BITS-1:0] sps,
                                  logic [CFG_DATA_BITS-1:0] step);
        write_reg(CFG_SYNC_PATTERN, pattern);
        write_reg(CFG_SYNC_LENGTH, length);
        write_reg(CFG_REPETITIONS, reps);
        write_reg(CFG_SAMPLES_PER_SYMBOL, sps);
        write_reg(CFG_PHASE_STEP, step);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every owed sample has come back and the pipeline is empty
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Mostly ticks; starts carry a small ones count most of the time
    function automatic ocwg_in_t random_item(int start_odds);
        ocwg_in_t item;
        item.opcode = ($urandom_range(1, start_odds) == 1) ? OP_START : OP_TICK;
        if (item.opcode == OP_START && $urandom_range(0, 3) != 0)
            item.ones_count = ONES_BITS'($urandom_range(0, 4));
        else
            item.ones_count = ONES_BITS'($urandom_range(0, 127));
        return item;
    endfunction

    initial
    begin
        int odds;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        calm      = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Reset registers: idle ticks, restarts, ones count at the extremes
        send_op(OP_TICK, 127);
        send_op(OP_TICK, 0);
        send_op(OP_START, 0);
        send_op(OP_TICK, 0);
        send_op(OP_TICK, 127);
        send_op(OP_START, 127);
        send_op(OP_TICK, 55);
        send_op(OP_START, 100);
        send_op(OP_START, 101);
        send_op(OP_TICK, 0);
        send_op(OP_START, 1);
        send_op(OP_TICK, 42);
        settle();

        // Short frame while the old one is still running: bounds shrink mid-frame
        apply_settings(32'h0000_0005, 32'd3, 32'd2, 32'd1, 32'h4000_0000);
        for (int i = CFG_PHASE_STEP + 1; i < INDEX_SPAN; i++)
            write_reg(CFG_INDEX_BITS'(i), $urandom);
        @(negedge clk);
        cfg_valid <= 1'b0;
        repeat (3) send_op(OP_TICK, 0);
        send_op(OP_START, 1);
        repeat (10) send_op(OP_TICK, 127);

        // Random phases under changing register settings
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                0: apply_settings(32'h0000_FFFF, 32'd1, 32'd1, 32'd1, 32'h0000_0000);
                1: apply_settings(32'h0000_0000, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
                2: apply_settings($urandom, 32'd31, 32'd15, 32'd1, $urandom);
                3: apply_settings($urandom, 32'd16, 32'd1, 32'd255, $urandom);
                4: apply_settings($urandom, 32'd17, 32'd2, 32'd2, $urandom);
                default:
                    // Upper data bits beyond each register's width are don't-care
                    apply_settings($urandom,
                                   ($urandom << SYNC_LEN_BITS) | $urandom_range(0, 31),
                                   ($urandom << REPS_BITS) | $urandom_range(0, 3),
                                   ($urandom << SPS_BITS) | $urandom_range(0, 3),
                                   $urandom);
            endcase
            if (p == PHASES - 1)
                calm = 1'b1;
            odds = $urandom_range(8, 64);
            repeat (ITEMS_PER_PHASE) send_item(random_item(odds));
        end
        settle();

        if (failures == 0 && pending == 0)
            $display("ook_command_waveform_generator_tb: PASS");
        else
            $display("ook_command_waveform_generator_tb: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/ocwg_pkg.sv
rtl/core/ocwg_sequencer.sv
rtl/core/ocwg_carrier_rom.sv
rtl/core/ook_command_waveform_generator.sv
rtl/core/ocwg_checker.sv
bench/ocwg_waveform_checker.sv
bench/ook_command_waveform_generator_tb.sv
